/* sv/mcq_pkg.sv */
// ----------------------------------------------------------------------------
// mcq_pkg
// Sizes and the entry layout used by the multicast queue module.
// ----------------------------------------------------------------------------
`default_nettype none

package mcq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DEST_COUNT = 9;

    localparam int DATA_W    = 32;
    localparam int SET_W     = 9;
    localparam int ID_W      = 4;
    localparam int OCC_W     = 5;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ENTRY_W   = 2 * DATA_W + DEST_COUNT;

    typedef logic [DEST_COUNT-1:0] dest_mask_t;

    typedef struct packed {
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] quantity;
        dest_mask_t        mask;
    } entry_t;

endpackage

`default_nettype wire

/* sv/mcq_ram.sv */
// ----------------------------------------------------------------------------
// mcq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/multicast_queue_per_dest_pop.sv */
// ----------------------------------------------------------------------------
// multicast_queue_per_dest_pop
// Push: accepted in IDLE, the entry written at once, the result registered from RESP.
// Pop: SCAN_RD and SCAN_CHK read and check each entry in turn, and SHIFT_RD and
// SHIFT_WR close up each later entry before RESP; one request at a time, paced by
// the RAM's registered read. A waiting result holds the next one in its last step.
// Synchronous active-low reset empties the queue; the RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module multicast_queue_per_dest_pop (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_func,
    input  wire logic [mcq_pkg::SET_W-1:0]         s_dest_set,
    input  wire logic [mcq_pkg::ID_W-1:0]          s_pop_dest_id,
    input  wire logic signed [mcq_pkg::DATA_W-1:0] s_entry_code,
    input  wire logic signed [mcq_pkg::DATA_W-1:0] s_entry_quantity,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_ok,
    output logic signed [mcq_pkg::DATA_W-1:0]      m_out_code,
    output logic signed [mcq_pkg::DATA_W-1:0]      m_out_quantity,
    output logic                                   m_entry_retired,
    output logic [mcq_pkg::OCC_W-1:0]              m_occupancy
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN_RD,
        SCAN_CHK,
        SHIFT_RD,
        SHIFT_WR,
        RESP
    } state_t;

    state_t                           state_reg;
    logic [mcq_pkg::CNT_W-1:0]        fill_count_reg;
    logic [mcq_pkg::IDX_W-1:0]        idx_reg;
    mcq_pkg::dest_mask_t              bit_reg;

    logic                             res_ok_reg;
    logic [mcq_pkg::DATA_W-1:0]       res_code_reg;
    logic [mcq_pkg::DATA_W-1:0]       res_quantity_reg;
    logic                             res_retired_reg;

    logic                             m_valid_reg;
    logic                             m_ok_reg;
    logic [mcq_pkg::DATA_W-1:0]       m_code_reg;
    logic [mcq_pkg::DATA_W-1:0]       m_quantity_reg;
    logic                             m_retired_reg;
    logic [mcq_pkg::OCC_W-1:0]        m_occupancy_reg;

    mcq_pkg::dest_mask_t              push_mask;
    mcq_pkg::dest_mask_t              pop_bit;
    mcq_pkg::dest_mask_t              new_mask;
    mcq_pkg::entry_t                  rd_entry;
    mcq_pkg::entry_t                  wr_entry;
    logic [mcq_pkg::ENTRY_W-1:0]      rdata;
    logic                             ram_we;
    logic [mcq_pkg::IDX_W-1:0]        ram_waddr;
    logic [mcq_pkg::IDX_W-1:0]        ram_raddr;
    logic [mcq_pkg::CNT_W-1:0]        idx_inc;
    logic [mcq_pkg::CNT_W-1:0]        idx_inc2;
    logic                             accept;
    logic                             full;
    logic                             id_valid;
    logic                             push_ok;
    logic                             hit;

    always_comb begin
        for (int k = 0; k < mcq_pkg::DEST_COUNT; k++) begin
            push_mask[k] = (k < mcq_pkg::SET_W) ? s_dest_set[k] : 1'b0;
        end
    end

    assign accept   = s_valid && s_ready;
    assign full     = (fill_count_reg == mcq_pkg::CNT_W'(mcq_pkg::CAPACITY));
    assign id_valid = (s_pop_dest_id != '0)
                      && (32'(s_pop_dest_id) <= 32'(mcq_pkg::DEST_COUNT));
    assign pop_bit  = mcq_pkg::dest_mask_t'(1) << (s_pop_dest_id - mcq_pkg::ID_W'(1));
    assign push_ok  = (push_mask != '0) && !full;

    assign rd_entry = mcq_pkg::entry_t'(rdata);
    assign new_mask = rd_entry.mask & ~bit_reg;
    assign hit      = (rd_entry.mask & bit_reg) != '0;
    assign idx_inc  = mcq_pkg::CNT_W'(idx_reg) + mcq_pkg::CNT_W'(1);
    assign idx_inc2 = mcq_pkg::CNT_W'(idx_reg) + mcq_pkg::CNT_W'(2);

    // The RAM is written by a push, a mask update or one close-up step.
    always_comb begin
        ram_we            = 1'b0;
        ram_waddr         = idx_reg;
        wr_entry          = rd_entry;
        ram_raddr         = idx_reg;
        case (state_reg)
            IDLE: begin
                ram_we            = accept && !s_func && push_ok;
                ram_waddr         = mcq_pkg::IDX_W'(fill_count_reg);
                wr_entry.code     = s_entry_code;
                wr_entry.quantity = s_entry_quantity;
                wr_entry.mask     = push_mask;
            end
            SCAN_CHK: begin
                ram_we        = hit && (new_mask != '0);
                wr_entry.mask = new_mask;
            end
            SHIFT_RD: begin
                ram_raddr = mcq_pkg::IDX_W'(idx_inc);
            end
            SHIFT_WR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mcq_ram #(
        .WIDTH (mcq_pkg::ENTRY_W),
        .DEPTH (mcq_pkg::CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (accept) begin
                        res_ok_reg       <= 1'b0;
                        res_code_reg     <= '0;
                        res_quantity_reg <= '0;
                        res_retired_reg  <= 1'b0;
                        bit_reg          <= pop_bit;
                        idx_reg          <= '0;
                        state_reg        <= RESP;
                        if (!s_func) begin
                            if (push_ok) begin
                                res_ok_reg     <= 1'b1;
                                fill_count_reg <= fill_count_reg + mcq_pkg::CNT_W'(1);
                            end
                        end else if (id_valid && (fill_count_reg != '0)) begin
                            state_reg <= SCAN_RD;
                        end
                    end
                end
                SCAN_RD: begin
                    state_reg <= SCAN_CHK;
                end
                SCAN_CHK: begin
                    if (hit) begin
                        res_ok_reg       <= 1'b1;
                        res_code_reg     <= rd_entry.code;
                        res_quantity_reg <= rd_entry.quantity;
                        if (new_mask != '0) begin
                            state_reg <= RESP;
                        end else begin
                            res_retired_reg <= 1'b1;
                            if (idx_inc == fill_count_reg) begin
                                fill_count_reg <= fill_count_reg - mcq_pkg::CNT_W'(1);
                                state_reg      <= RESP;
                            end else begin
                                state_reg <= SHIFT_RD;
                            end
                        end
                    end else if (idx_inc == fill_count_reg) begin
                        state_reg <= RESP;
                    end else begin
                        idx_reg   <= mcq_pkg::IDX_W'(idx_inc);
                        state_reg <= SCAN_RD;
                    end
                end
                SHIFT_RD: begin
                    state_reg <= SHIFT_WR;
                end
                SHIFT_WR: begin
                    idx_reg <= mcq_pkg::IDX_W'(idx_inc);
                    if (idx_inc2 == fill_count_reg) begin
                        fill_count_reg <= fill_count_reg - mcq_pkg::CNT_W'(1);
                        state_reg      <= RESP;
                    end else begin
                        state_reg <= SHIFT_RD;
                    end
                end
                RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_ok_reg        <= res_ok_reg;
                        m_code_reg      <= res_code_reg;
                        m_quantity_reg  <= res_quantity_reg;
                        m_retired_reg   <= res_retired_reg;
                        m_occupancy_reg <= mcq_pkg::OCC_W'(fill_count_reg);
                        state_reg       <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == IDLE);
    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_out_code      = m_code_reg;
    assign m_out_quantity  = m_quantity_reg;
    assign m_entry_retired = m_retired_reg;
    assign m_occupancy     = m_occupancy_reg;

    // The queue never holds more entries than it has room for.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= mcq_pkg::CNT_W'(mcq_pkg::CAPACITY))
        else $error("fill count above capacity");

    // Only a successful pop can retire an entry.
    a_retire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_retired_reg |-> m_ok_reg)
        else $error("entry retired by a failed request");

    // A failed request returns zero data.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> (m_code_reg == '0) && (m_quantity_reg == '0))
        else $error("failed request returned data");

    // The fill count is not updated from the RESP, SCAN_RD or SHIFT_RD state.
    a_fill_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RESP) || (state_reg == SCAN_RD) || (state_reg == SHIFT_RD)
        |=> $stable(fill_count_reg))
        else $error("fill count changed outside an update step");

endmodule

`default_nettype wire
